@@ rtl/sia_pkg.sv @@
// Shared types and constants for the session slot allocator.
package sia_pkg;

  localparam int unsigned MAX_SESSIONS_DEF = 64;
  localparam int unsigned HANDLE_BITS_DEF  = 32;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned SLOT_ID_W = 6;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned STATUS_W  = 2;

  // widest row of the in-use bitmap memory
  localparam int unsigned MAP_ROW_MAX = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_e;

endpackage

@@ rtl/sia_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sia_free_scan.sv @@
// Lowest-free-bit finder over one row of the in-use bitmap.
module sia_free_scan #(
  parameter int unsigned WIDTH = 64,
  localparam int unsigned IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] occupied_i,
  output logic             found_o,
  output logic [IDX_W-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!occupied_i[i]) begin
        found_o = 1'b1;
        idx_o   = IDX_W'(i);
      end
    end
  end

endmodule

@@ rtl/session_id_allocator.sv @@
// Session slot allocator: first-fit in-use bitmap plus handle table.
//
// Input channel: in_valid_i / in_stall_o carry one request word (opcode_i,
// slot_id_i, session_handle_i). Output channel: out_valid_o / out_stall_i
// carry one result word (status_o, assigned_slot_o, found_handle_o) for
// every request, in request order. A word moves at a clock edge with valid
// high and stall low.
// Both tables live in synchronous RAMs. The bitmap is held in rows of up to
// 64 bits; a request reads its row (and the handle) at the accept edge and
// the result is registered in the evaluate step once the output register is
// free; any bitmap or handle write lands at that same edge.
// An add scans bitmap rows one per cycle from row 0 while the output register
// is free, up to the first free slot (at most ceil(MAX_SESSIONS/64) rows).
// One request is in flight at a time: in_stall_o is high from the accept
// edge until the result has been written to the output register.
// Reset clears the per-row valid flags, so every slot reads as free; no
// clearing pass is needed. If the receiver stalls, the result holds in the
// output register; a later request is still taken but its result waits in
// the evaluate step until the register is free.
module session_id_allocator
  import sia_pkg::*;
#(
  parameter int unsigned MAX_SESSIONS = MAX_SESSIONS_DEF,
  parameter int unsigned HANDLE_BITS  = HANDLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [SLOT_ID_W-1:0] slot_id_i,
  input  logic [HANDLE_W-1:0]  session_handle_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [SLOT_ID_W-1:0] assigned_slot_o,
  output logic [HANDLE_W-1:0]  found_handle_o
);

  localparam int unsigned MAP_W    = (MAX_SESSIONS < MAP_ROW_MAX) ? MAX_SESSIONS : MAP_ROW_MAX;
  localparam int unsigned MAP_ROWS = (MAX_SESSIONS + MAP_W - 1) / MAP_W;
  localparam int unsigned COL_W    = $clog2(MAP_W);
  localparam int unsigned ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned SLOT_W   = $clog2(MAX_SESSIONS);
  localparam int unsigned LAST_BITS = MAX_SESSIONS - MAP_W * (MAP_ROWS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAP_ROWS - 1);
  // slots past the table in the last row count as taken
  localparam logic [MAP_W-1:0] LAST_PAD =
    ~((MAP_W'(1) << LAST_BITS) - MAP_W'(1));

  state_e state_q, state_d;

  op_e                    op_q;
  logic [COL_W-1:0]       col_q;
  logic                   range_ok_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [MAP_ROWS-1:0]    row_vld_q, row_vld_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [SLOT_ID_W-1:0]   slot_out_q, slot_out_d;
  logic [HANDLE_W-1:0]    handle_out_q, handle_out_d;

  logic                   accept;
  op_e                    op_in;
  logic [SLOT_W-1:0]      slot_in;
  logic                   can_out;
  logic                   load_out;

  logic                   map_we, map_re;
  logic [ROW_W-1:0]       map_raddr;
  logic [MAP_W-1:0]       map_wdata, map_rdata;
  logic                   hdl_we;
  logic [SLOT_W-1:0]      hdl_waddr;
  logic [HANDLE_BITS-1:0] hdl_rdata;

  logic [MAP_W-1:0]       row_used;
  logic [MAP_W-1:0]       occupied;
  logic                   scan_found;
  logic [COL_W-1:0]       scan_col;
  logic [SLOT_W-1:0]      new_slot;
  logic                   col_busy;

  assign op_in   = op_e'(opcode_i);
  assign slot_in = SLOT_W'(slot_id_i);
  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign can_out = !out_valid_q || !out_stall_i;

  // rows never written read as all free
  assign row_used = row_vld_q[row_q] ? map_rdata : '0;
  assign occupied = row_used | ((row_q == LAST_ROW) ? LAST_PAD : '0);
  assign col_busy = row_used[col_q];
  assign new_slot = SLOT_W'({row_q, scan_col});

  sia_free_scan #(
    .WIDTH (MAP_W)
  ) u_scan (
    .occupied_i (occupied),
    .found_o    (scan_found),
    .idx_o      (scan_col)
  );

  sia_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_ROWS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (row_q),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  sia_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (MAX_SESSIONS)
  ) u_hdl_ram (
    .clk_i   (clk_i),
    .we_i    (hdl_we),
    .waddr_i (hdl_waddr),
    .wdata_i (handle_q),
    .re_i    (accept),
    .raddr_i (slot_in),
    .rdata_o (hdl_rdata)
  );

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    row_vld_d    = row_vld_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    slot_out_d   = slot_out_q;
    handle_out_d = handle_out_q;
    load_out     = 1'b0;
    map_we       = 1'b0;
    map_re       = 1'b0;
    map_raddr    = row_q;
    map_wdata    = row_used;
    hdl_we       = 1'b0;
    hdl_waddr    = new_slot;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          map_re    = 1'b1;
          map_raddr = (op_in == OP_ADD) ? '0 : ROW_W'(slot_in >> COL_W);
          row_d     = map_raddr;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (can_out) begin
          status_d     = ST_OK;
          slot_out_d   = '0;
          handle_out_d = '0;
          load_out     = 1'b1;
          case (op_q)
            OP_ADD: begin
              if (scan_found) begin
                map_we     = 1'b1;
                map_wdata  = row_used | (MAP_W'(1) << scan_col);
                hdl_we     = 1'b1;
                slot_out_d = SLOT_ID_W'(new_slot);
              end else if (row_q == LAST_ROW) begin
                status_d = ST_FULL;
              end else begin
                // next row, result not ready yet
                load_out  = 1'b0;
                map_re    = 1'b1;
                map_raddr = row_q + ROW_W'(1);
                row_d     = map_raddr;
              end
            end
            OP_REMOVE: begin
              if (!range_ok_q) begin
                status_d = ST_RANGE;
              end else if (!col_busy) begin
                status_d = ST_NOT_IN_USE;
              end else begin
                map_we    = 1'b1;
                map_wdata = row_used & ~(MAP_W'(1) << col_q);
              end
            end
            OP_FIND: begin
              if (!range_ok_q) begin
                status_d = ST_RANGE;
              end else if (!col_busy) begin
                status_d = ST_NOT_IN_USE;
              end else begin
                handle_out_d = HANDLE_W'(hdl_rdata);
              end
            end
            default: begin
            end
          endcase
          if (map_we) begin
            row_vld_d[row_q] = 1'b1;
          end
          if (load_out) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (accept) begin
      op_q       <= op_in;
      col_q      <= COL_W'(slot_in);
      range_ok_q <= (32'(slot_id_i) < 32'(MAX_SESSIONS));
      handle_q   <= HANDLE_BITS'(session_handle_i);
    end
    if (load_out) begin
      status_q     <= status_d;
      slot_out_q   <= slot_out_d;
      handle_out_q <= handle_out_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign assigned_slot_o = slot_out_q;
  assign found_handle_o  = handle_out_q;

endmodule

@@ rtl/sia_checker.sv @@
// Port-level checks for the session slot allocator, bound to the top level.
module sia_checker
  import sia_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [SLOT_ID_W-1:0] assigned_slot_o,
  input logic [HANDLE_W-1:0]  found_handle_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(assigned_slot_o) && $stable(found_handle_o))
    else $error("result word changed while stalled");

  // one request in flight: busy right after an accepted word
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while a request is in flight");

  // a new result only follows a request that was being worked on
  a_result_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without a request");

  // failed requests carry no slot and no handle
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (assigned_slot_o == '0)
      && (found_handle_o == '0))
    else $error("failed request returned slot or handle");

  // never both a slot and a handle in one word
  a_slot_or_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (assigned_slot_o == '0) || (found_handle_o == '0))
    else $error("result word holds both slot and handle");

endmodule

bind session_id_allocator sia_checker u_sia_checker (.*);

@@ sim/session_id_allocator_tb.sv @@
// Self-checking testbench for the session slot allocator: directed, fill, random and stall tests.
module session_id_allocator_tb;
  import sia_pkg::*;

  localparam int unsigned NUM_SLOTS   = MAX_SESSIONS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_e               status;
    logic [SLOT_ID_W-1:0]  slot;
    logic [HANDLE_W-1:0]   handle;
  } alloc_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OPCODE_W-1:0]  opcode_i;
  logic [SLOT_ID_W-1:0] slot_id_i;
  logic [HANDLE_W-1:0]  session_handle_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [SLOT_ID_W-1:0] assigned_slot_o;
  logic [HANDLE_W-1:0]  found_handle_o;

  // predictor state
  logic [NUM_SLOTS-1:0] slot_busy;
  logic [NUM_SLOTS-1:0] slot_written;
  logic [HANDLE_W-1:0]  slot_handle [NUM_SLOTS];

  alloc_result_t pending_results [$];
  alloc_result_t want;
  int            mismatch_count;
  int unsigned   cycle_count;
  int            hold_left;
  bit            sender_idles;
  bit            receiver_idles;

  session_id_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .slot_id_i        (slot_id_i),
    .session_handle_i (session_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .assigned_slot_o  (assigned_slot_o),
    .found_handle_o   (found_handle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[session_id_allocator] ERROR");
      $finish;
    end
  end

  // first-fit allocation, applied at the accept edge
  function automatic alloc_result_t predict_request(op_e op, logic [SLOT_ID_W-1:0] slot,
                                                    logic [HANDLE_W-1:0] h);
    alloc_result_t r;
    bit            taken;
    r = '{status: ST_OK, slot: '0, handle: '0};
    taken = 1'b0;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!taken && !slot_busy[i]) begin
            taken           = 1'b1;
            slot_busy[i]    = 1'b1;
            slot_written[i] = 1'b1;
            slot_handle[i]  = h;
            r.slot          = SLOT_ID_W'(i);
          end
        end
        if (!taken) r.status = ST_FULL;
      end
      OP_REMOVE, OP_FIND: begin
        if (slot >= NUM_SLOTS) r.status = ST_RANGE;
        else if (!slot_busy[slot]) r.status = ST_NOT_IN_USE;
        else if (op == OP_REMOVE) begin
          slot_busy[slot]   = 1'b0;
          slot_handle[slot] = '0;
        end else r.handle = slot_handle[slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input op_e op, input logic [SLOT_ID_W-1:0] slot,
                              input logic [HANDLE_W-1:0] h);
    @(negedge clk_i);
    while (sender_idles && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    slot_id_i        <= slot;
    session_handle_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_request(op, slot, h));
  endtask

  // any slot already written once; busy ones preferred when asked
  function automatic logic [SLOT_ID_W-1:0] pick_slot(bit want_busy);
    logic [SLOT_ID_W-1:0] s;
    s = '0;
    for (int tries = 0; tries < 256; tries++) begin
      s = SLOT_ID_W'($urandom_range(0, 63));
      if (slot_written[s] && (!want_busy || slot_busy[s])) return s;
    end
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_written[i]) return SLOT_ID_W'(i);
    return s;
  endfunction

  function automatic logic [HANDLE_W-1:0] random_handle();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return HANDLE_W'($urandom());
    endcase
  endfunction

  task automatic send_random_request();
    int  pick;
    bit  busy_pref;
    op_e op;
    pick      = $urandom_range(0, 99);
    busy_pref = ($urandom_range(0, 99) < 85);
    if (pick < 35) op = OP_ADD;
    else if (pick < 60) op = OP_REMOVE;
    else if (pick < 90) op = OP_FIND;
    else op = OP_NOP;
    // slot_id is don't-care for add, so let it roam freely there
    if (op == OP_ADD) send_request(op, SLOT_ID_W'($urandom_range(0, 63)), random_handle());
    else send_request(op, pick_slot(busy_pref), random_handle());
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // receiver side: random stalls, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= receiver_idles && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with nothing expected (status %0d slot %0d handle %h)",
                 $time, status_o, assigned_slot_o, found_handle_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (assigned_slot_o !== want.slot) begin
          mismatch_count++;
          $display("%0t: assigned_slot expected %0d actual %0d", $time, want.slot,
                   assigned_slot_o);
        end
        if (found_handle_o !== want.handle) begin
          mismatch_count++;
          $display("%0t: found_handle expected %h actual %h", $time, want.handle,
                   found_handle_o);
        end
      end
    end
  end

  // extremes of the handle, free-slot errors, unused opcode, slot reuse.
  // Out-of-range slots cannot be formed: the 6-bit field never reaches 64.
  task automatic test_directed();
    send_request(OP_ADD, 6'd0, '0);
    send_request(OP_ADD, 6'd63, '1);
    send_request(OP_ADD, 6'd21, 32'h8000_0001);
    send_request(OP_FIND, 6'd0, '1);
    send_request(OP_FIND, 6'd1, '0);
    send_request(OP_FIND, 6'd2, 32'h5555_5555);
    send_request(OP_REMOVE, 6'd1, '0);
    send_request(OP_FIND, 6'd1, '0);
    send_request(OP_REMOVE, 6'd1, '1);
    send_request(OP_NOP, 6'd2, '1);
    send_request(OP_NOP, 6'd0, '0);
    send_request(OP_ADD, 6'd42, 32'h1234_5678);
    send_request(OP_FIND, 6'd1, '0);
    send_request(OP_REMOVE, 6'd0, '0);
    send_request(OP_REMOVE, 6'd2, '0);
    send_request(OP_FIND, 6'd0, '0);
    wait_for_results();
  endtask

  task automatic test_fill_to_full();
    while ($countones(slot_busy) < NUM_SLOTS)
      send_request(OP_ADD, SLOT_ID_W'($urandom_range(0, 63)), random_handle());
    send_request(OP_ADD, 6'd0, '1);
    send_request(OP_ADD, 6'd63, random_handle());
    send_request(OP_FIND, 6'd63, '0);
    send_request(OP_FIND, 6'd32, '0);
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_random_request();
  endtask

  task automatic test_receiver_hold();
    hold_left = 80;
    repeat (12) send_random_request();
  endtask

  task automatic test_sender_pause();
    wait_for_results();
    repeat (20) send_random_request();
  endtask

  task automatic test_no_idle_stretch();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_mix(100);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_NOP;
    slot_id_i        = '0;
    session_handle_i = '0;
    out_stall_i      = 1'b0;
    slot_busy        = '0;
    slot_written     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_handle[i] = '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    hold_left        = 0;
    sender_idles     = 1'b1;
    receiver_idles   = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_to_full();
    test_random_mix(120);
    test_receiver_hold();
    test_sender_pause();
    test_no_idle_stretch();
    test_random_mix(120);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("[session_id_allocator] OK");
    end else begin
      $display("[session_id_allocator] ERROR");
    end
    $finish;
  end

endmodule
